[src/sitoa_pkg.sv]
// shared types and constants for the signed integer to decimal text converter
package sitoa_pkg;

    localparam int VALUE_W    = 64;
    localparam int CHAR_W     = 6;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 19;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic convert;
        logic shift_out;
    } cell_ctrl_t;

endpackage

[src/sitoa_cell.sv]
// one bcd digit cell of the shift-and-add-3 chain
module sitoa_cell (
    input  logic                              clk,
    input  sitoa_pkg::cell_ctrl_t             ctrl,
    input  logic                              bit_in,
    input  logic [sitoa_pkg::DIGIT_W-1:0]     digit_in,
    output logic                              carry_out,
    output logic [sitoa_pkg::DIGIT_W-1:0]     digit
);
    import sitoa_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adj;

    // add 3 before the shift when the digit would overflow past 9
    assign adj       = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign carry_out = adj[DIGIT_W-1];
    assign digit     = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        priority if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.convert)
        begin
            digit_next = {adj[DIGIT_W-2:0], bit_in};
        end
        else if (ctrl.shift_out)
        begin
            digit_next = digit_in;
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

[src/signed_int_to_decimal_ascii.sv]
// an item that is taken is converted by double dabble, its leading zeros are dropped
// and the first character (the sign of a negative value) is then registered;
// the other characters follow one per cycle while the output side does not stall.
// the input stalls from acceptance until the last character is registered.
// reset: rst_n asynchronous, active low; clears the controller and the output valid.
module signed_int_to_decimal_ascii (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [sitoa_pkg::VALUE_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [sitoa_pkg::CHAR_W-1:0]      character,
    output logic                              is_last
);
    import sitoa_pkg::*;

    state_t                 state_reg, state_next;
    logic [VALUE_W-1:0]     mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]   remain_reg, remain_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      character_reg, character_next;
    logic                   is_last_reg, is_last_next;

    cell_ctrl_t             ctrl;
    logic                   accept;
    logic                   out_free;
    logic [NUM_DIGITS:0]    carry;
    logic [DIGIT_W-1:0]     digits [NUM_DIGITS+1];
    logic [DIGIT_W-1:0]     top_digit;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign character = character_reg;
    assign is_last   = is_last_reg;

    assign carry[0]  = mag_reg[VALUE_W-1];
    assign digits[0] = '0;
    assign top_digit = digits[NUM_DIGITS];

    genvar gi;
    generate
        for (gi = 0; gi < NUM_DIGITS; gi++)
        begin : g_cell
            sitoa_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .bit_in    (carry[gi]),
                .digit_in  (digits[gi]),
                .carry_out (carry[gi+1]),
                .digit     (digits[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        bit_cnt_next   = bit_cnt_reg;
        remain_next    = remain_reg;
        character_next = character_reg;
        is_last_next   = is_last_reg;
        out_valid_next = out_valid_reg && out_stall;
        ctrl           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl.clear   = 1'b1;
                    neg_next     = value[VALUE_W-1];
                    mag_next     = value[VALUE_W-1] ? (~value + 1'b1) : value;
                    bit_cnt_next = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctrl.convert = 1'b1;
                mag_next     = {mag_reg[VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1))
                begin
                    remain_next = DIG_CNT_W'(NUM_DIGITS);
                    state_next  = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, keeping at least one digit
                if (top_digit == '0 && remain_reg > 1)
                begin
                    ctrl.shift_out = 1'b1;
                    remain_next    = remain_reg - 1'b1;
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    character_next = CHAR_MINUS;
                    is_last_next   = 1'b0;
                    state_next     = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    character_next = CHAR_ZERO + CHAR_W'(top_digit);
                    is_last_next   = (remain_reg == 1);
                    ctrl.shift_out = 1'b1;
                    remain_next    = remain_reg - 1'b1;
                    if (remain_reg == 1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            remain_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            remain_reg    <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        character_reg <= character_next;
        is_last_reg   <= is_last_next;
    end

endmodule
